// File: sv/wss_pkg.sv
// shared types and constants for the wide substring search block
// no dependencies; used by wss_cell, wide_substring_search and the testbench
package wss_pkg;

  // pattern capacity and text position range
  localparam int unsigned PAT_MAX = 32;
  localparam int unsigned LEN_W = $clog2(PAT_MAX + 1);
  localparam longint unsigned TEXT_MAX = 64'd65536;
  localparam longint unsigned POS_LIMIT = (TEXT_MAX < 64'd65536) ? TEXT_MAX : 64'd65536;
  localparam int unsigned TP_W = 17;
  localparam int unsigned CH_W = 32;
  localparam int unsigned POS_W = 16;

  // command codes
  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_TEXT   = 2'd2,
    CMD_END    = 2'd3
  } cmd_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_TOO_LONG  = 2'd2,
    ST_TEXT_OVF  = 2'd3
  } status_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic clr;     // clear match flag
    logic wr;      // load pattern char
    logic shift;   // take a text char
    logic active;  // cell index is below the pattern length
    logic last;    // cell holds the final pattern char
  } cell_ctrl_t;

endpackage

// File: sv/wide_substring_search.sv
// top level of the wide substring search block
// depends on wss_pkg and wss_cell
//
// Finds the first occurrence of a pattern of 32-bit characters in a streamed
// text. Command 0 clears, 1 appends a pattern char, 2 feeds a text char, 3
// ends the text (a zero text char ends it too). Each search returns one
// result item: found with its start position, not found, pattern too long or
// text position overflow; later items are ignored until the next clear. The
// block takes one item every cycle when not stalled: every text char is
// compared against all pattern chars at once in a row of PAT_MAX cells, each
// passing its match flag to its neighbor, and the hit from the cell holding
// the last pattern char is known in the same cycle. A result waits in an output
// register; input stalls only while that register is full and stalled.
module wide_substring_search (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                cmd,
  input  logic [wss_pkg::CH_W-1:0]  ch,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                status,
  output logic [wss_pkg::POS_W-1:0] position
);
  import wss_pkg::*;

  logic [LEN_W-1:0] pat_len, pat_len_next;
  logic [TP_W-1:0]  tp, tp_next;
  logic             done, done_next;

  logic             acc;
  logic             do_clear, do_append, do_step;
  logic             res_valid;
  logic [1:0]       res_status;
  logic [POS_W-1:0] res_pos;

  cell_ctrl_t       ctrl [PAT_MAX];
  logic [PAT_MAX-1:0] flags, hits;
  logic             any_hit;

  assign in_stall = out_valid && out_stall;
  assign acc      = in_valid && !in_stall;
  assign any_hit  = |hits;

  // row of pattern cells
  genvar gi;
  generate
    for (gi = 0; gi < PAT_MAX; gi++) begin : g_cell
      logic prev;
      if (gi == 0) begin : g_first
        assign prev = 1'b1;
      end else begin : g_rest
        assign prev = flags[gi-1];
      end
      assign ctrl[gi] = '{
        clr:    do_clear,
        wr:     do_append && (pat_len == LEN_W'(gi)),
        shift:  do_step,
        active: LEN_W'(gi) < pat_len,
        last:   pat_len == LEN_W'(gi + 1)
      };
      wss_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (ctrl[gi]),
        .ch        (ch),
        .prev_flag (prev),
        .flag      (flags[gi]),
        .hit       (hits[gi])
      );
    end
  endgenerate

  // command decode and search sequencing
  always_comb begin
    do_clear     = 1'b0;
    do_append    = 1'b0;
    do_step      = 1'b0;
    res_valid    = 1'b0;
    res_status   = ST_FOUND;
    res_pos      = '0;
    pat_len_next = pat_len;
    tp_next      = tp;
    done_next    = done;
    if (acc) begin
      if (cmd == CMD_CLEAR) begin
        do_clear     = 1'b1;
        pat_len_next = '0;
        tp_next      = '0;
        done_next    = 1'b0;
      end else if (!done) begin
        case (cmd)
          CMD_APPEND: begin
            if (tp == '0 && ch != '0) begin
              if (pat_len >= LEN_W'(PAT_MAX)) begin
                res_valid  = 1'b1;
                res_status = ST_TOO_LONG;
              end else begin
                do_append    = 1'b1;
                pat_len_next = pat_len + LEN_W'(1);
              end
            end
          end
          CMD_TEXT: begin
            if (ch == '0) begin
              res_valid  = 1'b1;
              res_status = (pat_len == '0) ? ST_FOUND : ST_NOT_FOUND;
            end else if (tp >= TP_W'(POS_LIMIT)) begin
              res_valid  = 1'b1;
              res_status = ST_TEXT_OVF;
            end else if (pat_len == '0) begin
              res_valid  = 1'b1;
              res_status = ST_FOUND;
            end else begin
              do_step = 1'b1;
              if (any_hit) begin
                res_valid  = 1'b1;
                res_status = ST_FOUND;
                res_pos    = tp[POS_W-1:0] - POS_W'(pat_len) + POS_W'(1);
              end else begin
                tp_next = tp + TP_W'(1);
              end
            end
          end
          CMD_END: begin
            res_valid  = 1'b1;
            res_status = (pat_len == '0) ? ST_FOUND : ST_NOT_FOUND;
          end
          default: begin
            res_valid = 1'b0;
          end
        endcase
        if (res_valid) begin
          done_next = 1'b1;
        end
      end
    end
  end

  // search state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pat_len <= '0;
      tp      <= '0;
      done    <= 1'b0;
    end else begin
      pat_len <= pat_len_next;
      tp      <= tp_next;
      done    <= done_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      status   <= res_status;
      position <= res_pos;
    end
  end

  // only the cell holding the last pattern char can report a hit
  assert property (@(posedge clk) disable iff (rst) $onehot0(hits))
    else $error("more than one cell reports a hit");

  // the cell just past the pattern length never holds a partial match
  assert property (@(posedge clk) disable iff (rst)
    (pat_len < LEN_W'(PAT_MAX)) |-> (flags[pat_len[LEN_W-2:0]] == 1'b0))
    else $error("match flag set beyond pattern length");

  // a result always closes the search
  assert property (@(posedge clk) disable iff (rst) res_valid |=> done)
    else $error("search not marked done after a result");

  // a found position never lies past the current text position
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FOUND) |-> ({1'b0, position} <= tp))
    else $error("found position beyond text position");

endmodule

// File: sv/wss_cell.sv
// one pattern cell: a stored pattern char and its partial-match flag
// depends on wss_pkg
module wss_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  wss_pkg::cell_ctrl_t      ctrl,
  input  logic [wss_pkg::CH_W-1:0] ch,
  input  logic                     prev_flag,
  output logic                     flag,
  output logic                     hit
);
  import wss_pkg::*;

  logic [CH_W-1:0] pat_ch;
  logic            flag_next;

  // flag of this cell after the current text char
  assign flag_next = prev_flag && (pat_ch == ch);
  assign hit       = ctrl.last && flag_next;

  // pattern char store, no reset needed
  always_ff @(posedge clk) begin
    if (ctrl.wr) begin
      pat_ch <= ch;
    end
  end

  // partial-match flag, handed to the next cell each text item
  always_ff @(posedge clk) begin
    if (rst || ctrl.clr || ctrl.wr) begin
      flag <= 1'b0;
    end else if (ctrl.shift && ctrl.active) begin
      flag <= flag_next;
    end
  end

endmodule

// File: dv/testbench.sv
// self-checking testbench for the wide substring search block
// depends on wss_pkg and the wide_substring_search rtl
`timescale 1ns / 1ps

module testbench;
  import wss_pkg::*;

  typedef struct {
    status_t             st;
    logic [POS_W-1:0]    pos;
  } search_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [1:0]       cmd = 2'd0;
  logic [CH_W-1:0]  ch = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [1:0]       status;
  logic [POS_W-1:0] position;

  // search state mirrored by the predictor
  logic [CH_W-1:0]    pat_chars [PAT_MAX];
  int unsigned        pat_len = 0;
  bit [PAT_MAX-1:0]   match_flags = '0;
  int unsigned        text_pos = 0;
  bit                 search_finished = 1'b0;

  search_result_t pending_results [$];
  int             fail_count = 0;
  int             sent_count = 0;
  int             idle_pct = 0;
  int             stall_pct = 0;

  wide_substring_search i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .ch        (ch),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .position  (position)
  );

  always #1 clk = ~clk;

  // receiver stall
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("mismatch: %s", msg);
    end
  endtask

  task automatic post_result(input status_t st, input int unsigned pos);
    search_result_t r;
    r.st = st;
    r.pos = pos[POS_W-1:0];
    pending_results.push_back(r);
    search_finished = 1'b1;
  endtask

  // expected outcome of one accepted item
  task automatic predict_search(input cmd_t c, input logic [CH_W-1:0] d);
    bit [PAT_MAX-1:0] nxt;
    int unsigned i;
    nxt = match_flags;
    if (c == CMD_CLEAR) begin
      pat_len = 0;
      match_flags = '0;
      text_pos = 0;
      search_finished = 1'b0;
      return;
    end
    if (search_finished) return;
    if (c == CMD_APPEND) begin
      if (text_pos != 0 || d == '0) return;
      if (pat_len >= PAT_MAX) begin
        post_result(ST_TOO_LONG, 0);
        return;
      end
      pat_chars[pat_len] = d;
      match_flags[pat_len] = 1'b0;
      pat_len++;
      return;
    end
    // end of text, explicit or by a zero char
    if (c == CMD_END || d == '0) begin
      post_result((pat_len == 0) ? ST_FOUND : ST_NOT_FOUND, 0);
      return;
    end
    if (text_pos >= POS_LIMIT) begin
      post_result(ST_TEXT_OVF, 0);
      return;
    end
    if (pat_len == 0) begin
      post_result(ST_FOUND, 0);
      return;
    end
    // shift the partial match flags by one text char
    for (i = 0; i < pat_len; i++) begin
      nxt[i] = ((i == 0) ? 1'b1 : match_flags[i-1]) && (pat_chars[i] == d);
    end
    match_flags = nxt;
    if (match_flags[pat_len-1]) begin
      post_result(ST_FOUND, text_pos - (pat_len - 1));
      return;
    end
    text_pos++;
  endtask

  // send one item, with an optional idle gap before it
  task automatic send_item(input cmd_t c, input logic [CH_W-1:0] d);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      cmd <= 2'($urandom_range(3));
      ch <= $urandom;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    cmd <= c;
    ch <= d;
    do @(posedge clk); while (in_stall);
    predict_search(c, d);
    sent_count++;
  endtask

  // result checker
  always @(posedge clk) begin : check_results
    search_result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        note_failure($sformatf("unexpected result status %0d position %0d",
                               status, position));
      end else begin
        exp_r = pending_results.pop_front();
        if (status !== exp_r.st) begin
          note_failure($sformatf("status expected %0d actual %0d", exp_r.st, status));
        end
        if (position !== exp_r.pos) begin
          note_failure($sformatf("position expected %0d actual %0d",
                                 exp_r.pos, position));
        end
      end
    end
  end

  // empty pattern, zero chars, ignored items and a simple hit
  task automatic test_directed_basic();
    send_item(CMD_CLEAR, '0);
    send_item(CMD_END, '0);
    send_item(CMD_CLEAR, 32'hFFFF_FFFF);
    send_item(CMD_TEXT, 32'hFFFF_FFFF);
    send_item(CMD_CLEAR, '0);
    send_item(CMD_TEXT, '0);
    // zero append is dropped; hit at position 1
    send_item(CMD_CLEAR, '0);
    send_item(CMD_APPEND, 32'hFFFF_FFFF);
    send_item(CMD_APPEND, '0);
    send_item(CMD_APPEND, 32'h0000_0001);
    send_item(CMD_TEXT, 32'hFFFF_FFFF);
    send_item(CMD_TEXT, 32'hFFFF_FFFF);
    send_item(CMD_TEXT, 32'h0000_0001);
    // ignored once done
    send_item(CMD_TEXT, 32'h0000_0001);
    send_item(CMD_APPEND, 32'h0000_0002);
    send_item(CMD_END, '0);
    // append after text began is dropped
    send_item(CMD_CLEAR, '0);
    send_item(CMD_APPEND, 32'hA5A5_5A5A);
    send_item(CMD_TEXT, 32'h5A5A_A5A5);
    send_item(CMD_APPEND, 32'h5A5A_A5A5);
    send_item(CMD_TEXT, 32'h5A5A_A5A5);
    send_item(CMD_TEXT, '0);
    send_item(CMD_CLEAR, '0);
    send_item(CMD_APPEND, 32'h8000_0000);
    send_item(CMD_END, 32'h8000_0000);
  endtask

  // longest pattern that fits, and one char past it
  task automatic test_pattern_length();
    logic [CH_W-1:0] chars [PAT_MAX];
    int k;
    for (k = 0; k < PAT_MAX; k++) chars[k] = $urandom | 32'h1;
    send_item(CMD_CLEAR, '0);
    for (k = 0; k < PAT_MAX; k++) send_item(CMD_APPEND, chars[k]);
    send_item(CMD_TEXT, chars[PAT_MAX-1]);
    for (k = 0; k < PAT_MAX; k++) send_item(CMD_TEXT, chars[k]);
    send_item(CMD_CLEAR, '0);
    for (k = 0; k < PAT_MAX + 1; k++) send_item(CMD_APPEND, chars[k % PAT_MAX]);
    send_item(CMD_APPEND, 32'h1234_5678);
    send_item(CMD_TEXT, chars[0]);
    send_item(CMD_END, '0);
  endtask

  // hits far into the text for one and two char patterns
  task automatic test_position_range();
    int k;
    send_item(CMD_CLEAR, '0);
    send_item(CMD_APPEND, 32'd5);
    for (k = 0; k < 60; k++) send_item(CMD_TEXT, 32'd7);
    send_item(CMD_TEXT, 32'd5);
    // partial match completed by the following char
    send_item(CMD_CLEAR, '0);
    send_item(CMD_APPEND, 32'd5);
    send_item(CMD_APPEND, 32'd6);
    for (k = 0; k < 60; k++) send_item(CMD_TEXT, 32'd7);
    send_item(CMD_TEXT, 32'd5);
    send_item(CMD_TEXT, 32'd6);
    send_item(CMD_END, '0);
  endtask

  // one search with random content drawn from a small alphabet
  task automatic run_random_search();
    logic [CH_W-1:0] alphabet [3];
    logic [CH_W-1:0] c;
    int asz, n_pat, n_text, r, k;
    asz = $urandom_range(1, 3);
    for (k = 0; k < 3; k++) alphabet[k] = $urandom;
    // occasional noise items
    if ($urandom_range(99) < 5) begin
      repeat ($urandom_range(1, 3)) send_item(cmd_t'($urandom_range(3)), $urandom);
    end
    if ($urandom_range(99) < 95) send_item(CMD_CLEAR, $urandom);
    r = $urandom_range(99);
    if (r < 75) n_pat = $urandom_range(0, 5);
    else if (r < 90) n_pat = $urandom_range(6, PAT_MAX);
    else n_pat = $urandom_range(PAT_MAX + 1, PAT_MAX + 3);
    for (k = 0; k < n_pat; k++) begin
      c = ($urandom_range(99) < 4) ? '0 : alphabet[$urandom_range(asz - 1)];
      send_item(CMD_APPEND, c);
    end
    n_text = $urandom_range(0, 40);
    for (k = 0; k < n_text; k++) begin
      r = $urandom_range(99);
      if (r < 88) c = alphabet[$urandom_range(asz - 1)];
      else if (r < 96) c = $urandom;
      else c = '0;
      send_item(($urandom_range(99) < 3) ? CMD_APPEND : CMD_TEXT, c);
    end
    if ($urandom_range(99) < 60) send_item(CMD_END, $urandom);
  endtask

  task automatic test_random(input int n_items, input int idle, input int stall);
    int start;
    idle_pct = idle;
    stall_pct = stall;
    start = sent_count;
    while (sent_count - start < n_items) run_random_search();
  endtask

  initial begin
    int waited;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed_basic();
    test_pattern_length();
    test_position_range();
    test_random(300, 0, 0);
    test_random(300, 67, 0);
    test_random(300, 0, 67);
    test_random(330, 29, 29);
    in_valid <= 1'b0;
    // drain outstanding results
    waited = 0;
    while (pending_results.size() != 0 && waited < 10000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    while (pending_results.size() != 0) begin
      void'(pending_results.pop_front());
      note_failure("expected result never arrived");
    end
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
